// ----- rtl/core/pcp_pkg.sv -----
// Shared types, widths and codes for the polygon plane clip stage.
package pcp_pkg;

   // Default width of a vertex index.
   localparam int INDEX_BITS_DEFAULT = 17;

   // Fixed field widths.
   localparam int DIST_BITS  = 32;
   localparam int FRAC_BITS  = 17;
   localparam int COUNT_BITS = 16;
   localparam int DATA_BITS  = 32;
   localparam int ADDR_BITS  = 3;

   // The divider makes one quotient bit per step.
   localparam int DIV_STEPS  = FRAC_BITS;
   localparam int STEP_BITS  = $clog2(DIV_STEPS + 1);

   // Magnitudes used by the divider.
   localparam int NUM_BITS   = DIST_BITS;
   localparam int DEN_BITS   = DIST_BITS + 1;
   localparam int REM_BITS   = DIST_BITS + 2;

   // Request commands.
   localparam logic CMD_PRIME   = 1'b0;
   localparam logic CMD_PROCESS = 1'b1;

   // Result kinds.
   localparam logic KIND_KEPT = 1'b0;
   localparam logic KIND_NEW  = 1'b1;

   // Register word index of the new index base.
   localparam int REG_NEW_INDEX_BASE = 0;

   // Fraction value meaning one.
   localparam logic [FRAC_BITS-1:0] FRAC_ONE = FRAC_BITS'(1) << (FRAC_BITS - 1);

   // Handshake between the sequencer and the divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- rtl/core/pcp_if.sv -----
// Request and result channel interfaces of the polygon plane clip stage.
interface pcp_req_if
   import pcp_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic signed [INDEX_BITS-1:0] vertex_index;
   logic signed [DIST_BITS-1:0]  distance;

   modport source (output valid, command, vertex_index, distance, input ready);
   modport sink   (input valid, command, vertex_index, distance, output ready);
endinterface

interface pcp_rsp_if
   import pcp_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic signed [INDEX_BITS-1:0] out_index;
   logic signed [INDEX_BITS-1:0] from_index;
   logic signed [INDEX_BITS-1:0] to_index;
   logic [FRAC_BITS-1:0]         fraction;
   logic                         last;

   modport source (output valid, kind, out_index, from_index, to_index, fraction, last,
                   input ready);
   modport sink   (input valid, kind, out_index, from_index, to_index, fraction, last,
                   output ready);
endinterface

// ----- rtl/core/polygon_plane_clip_stage.sv -----
// Top level of the polygon plane clip stage: sequencer, state and result register.
//
//  channel   | direction | handshake          | carries
//  req_chan  | in        | valid/ready        | command, vertex_index, distance
//  rsp_chan  | out       | valid/ready        | kind, out_index, from/to_index, fraction, last
//  csr (APB) | in        | psel/penable       | new_index_base at word 0
//
// A prime request, or one whose edge and vertex both stay outside, gives no result and
// leaves the sequencer in ST_IDLE. A request that keeps its vertex without a crossing
// goes to ST_SEND and waits there on rsp_chan.ready. A crossing starts the radix-2
// divider, waits in ST_DIVIDE for its done, loads the fraction into the result register,
// then delivers the crossing and, if the vertex is inside, the vertex from ST_SEND.
// Reset is synchronous and clears the state to zero. After a request that gives results,
// req_chan.ready is low until the last result of that request has been taken.
module polygon_plane_clip_stage
   import pcp_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEFAULT
)(
   input  logic                 clock,
   input  logic                 reset,
   pcp_req_if.sink              req_chan,
   pcp_rsp_if.source            rsp_chan,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SEND
   } state_type;

   state_type state_ff, state_in;

   logic [INDEX_BITS-1:0] prev_vertex_ff, prev_vertex_in;
   logic [DIST_BITS-1:0]  prev_dist_ff, prev_dist_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  keep_ff, keep_in;
   logic [INDEX_BITS-1:0] keep_index_ff, keep_index_in;

   logic                  kind_ff, kind_in;
   logic [INDEX_BITS-1:0] out_index_ff, out_index_in;
   logic [INDEX_BITS-1:0] from_ff, from_in;
   logic [INDEX_BITS-1:0] to_ff, to_in;
   logic [FRAC_BITS-1:0]  frac_ff, frac_in;
   logic                  last_ff, last_in;

   logic [COUNT_BITS-1:0] base;
   logic                  base_written;
   div_status_type        div_status;
   logic [FRAC_BITS-1:0]  quotient;
   logic                  div_start;

   logic                  accept;
   logic                  prev_in_side;
   logic                  cur_in_side;
   logic                  crossing;
   logic [DEN_BITS-1:0]   diff;
   logic [NUM_BITS-1:0]   num;
   logic [DEN_BITS-1:0]   den;
   logic [COUNT_BITS:0]   new_number;

   pcp_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .new_index_base (base),
      .base_written   (base_written)
   );

   pcp_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (num),
      .denominator (den),
      .status      (div_status),
      .quotient    (quotient)
   );

   // Side tests and divider operands from the held and incoming distances.
   assign accept       = req_chan.valid && req_chan.ready;
   assign prev_in_side = !prev_dist_ff[DIST_BITS-1];
   assign cur_in_side  = !req_chan.distance[DIST_BITS-1];
   assign crossing     = prev_in_side != cur_in_side;
   assign diff = {prev_dist_ff[DIST_BITS-1], prev_dist_ff}
               - {req_chan.distance[DIST_BITS-1], req_chan.distance};
   assign num  = prev_dist_ff[DIST_BITS-1] ? (~prev_dist_ff + NUM_BITS'(1)) : prev_dist_ff;
   assign den  = diff[DEN_BITS-1] ? (~diff + DEN_BITS'(1)) : diff;
   assign new_number = {1'b0, base} + {1'b0, count_ff};

   assign div_start = (state_ff == ST_IDLE) && accept
                      && (req_chan.command == CMD_PROCESS) && crossing;

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      prev_vertex_in = prev_vertex_ff;
      prev_dist_in   = prev_dist_ff;
      count_in       = count_ff;
      keep_in        = keep_ff;
      keep_index_in  = keep_index_ff;
      kind_in        = kind_ff;
      out_index_in   = out_index_ff;
      from_in        = from_ff;
      to_in          = to_ff;
      frac_in        = frac_ff;
      last_in        = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               prev_vertex_in = req_chan.vertex_index;
               prev_dist_in   = req_chan.distance;
               if (req_chan.command == CMD_PROCESS) begin
                  keep_index_in = req_chan.vertex_index;
                  if (crossing) begin
                     kind_in      = KIND_NEW;
                     out_index_in = ~INDEX_BITS'(new_number);
                     from_in      = prev_vertex_ff;
                     to_in        = req_chan.vertex_index;
                     keep_in      = cur_in_side;
                     count_in     = count_ff + COUNT_BITS'(1);
                     state_in     = ST_DIVIDE;
                  end else if (cur_in_side) begin
                     kind_in      = KIND_KEPT;
                     out_index_in = req_chan.vertex_index;
                     from_in      = '0;
                     to_in        = '0;
                     frac_in      = '0;
                     last_in      = 1'b1;
                     keep_in      = 1'b0;
                     state_in     = ST_SEND;
                  end
               end
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               frac_in  = quotient;
               last_in  = !keep_ff;
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (rsp_chan.ready) begin
               if (keep_ff) begin
                  // The crossing went out; the current vertex follows.
                  kind_in      = KIND_KEPT;
                  out_index_in = keep_index_ff;
                  from_in      = '0;
                  to_in        = '0;
                  frac_in      = '0;
                  last_in      = 1'b1;
                  keep_in      = 1'b0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // A base write restarts numbering of new vertices.
      if (base_written) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         prev_vertex_ff <= '0;
         prev_dist_ff   <= '0;
         count_ff       <= '0;
         keep_ff        <= 1'b0;
      end else begin
         state_ff       <= state_in;
         prev_vertex_ff <= prev_vertex_in;
         prev_dist_ff   <= prev_dist_in;
         count_ff       <= count_in;
         keep_ff        <= keep_in;
      end
      keep_index_ff <= keep_index_in;
      kind_ff       <= kind_in;
      out_index_ff  <= out_index_in;
      from_ff       <= from_in;
      to_ff         <= to_in;
      frac_ff       <= frac_in;
      last_ff       <= last_in;
   end

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = (state_ff == ST_SEND);
   assign rsp_chan.kind       = kind_ff;
   assign rsp_chan.out_index  = out_index_ff;
   assign rsp_chan.from_index = from_ff;
   assign rsp_chan.to_index   = to_ff;
   assign rsp_chan.fraction   = frac_ff;
   assign rsp_chan.last       = last_ff;

endmodule

// ----- rtl/core/pcp_divider.sv -----
// Restoring radix-2 divider that makes the crossing fraction one bit per cycle.
module pcp_divider
   import pcp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_BITS-1:0]  numerator,
   input  logic [DEN_BITS-1:0]  denominator,
   output div_status_type       status,
   output logic [FRAC_BITS-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [DEN_BITS-1:0]  den_ff, den_in;
   logic [FRAC_BITS-1:0] quo_ff, quo_in;
   logic [REM_BITS:0]    trial;
   logic                 fits;

   // One trial subtraction; the numerator never exceeds the denominator,
   // so the first step yields the integer bit of the fraction.
   assign trial = {1'b0, rem_ff} - {2'b00, den_ff};
   assign fits  = !trial[REM_BITS];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_BITS'(DIV_STEPS);
         rem_in  = REM_BITS'(numerator);
         den_in  = denominator;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in  = (fits ? trial[REM_BITS-1:0] : rem_ff) << 1;
         quo_in  = {quo_ff[FRAC_BITS-2:0], fits};
         step_in = step_ff - STEP_BITS'(1);
         if (step_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// ----- rtl/core/pcp_csr.sv -----
// Configuration register file: holds the base number for new vertices.
module pcp_csr
   import pcp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_BITS-1:0]  paddr,
   input  logic [DATA_BITS-1:0]  pwdata,
   output logic [DATA_BITS-1:0]  prdata,
   output logic                  pready,
   output logic [COUNT_BITS-1:0] new_index_base,
   output logic                  base_written
);

   logic [COUNT_BITS-1:0] base_ff, base_in;
   logic                  hit;
   logic                  write_en;

   // Word address decode.
   assign hit      = (paddr[ADDR_BITS-1:2] == (ADDR_BITS-2)'(REG_NEW_INDEX_BASE));
   assign write_en = psel && penable && pwrite && hit;

   assign base_in = write_en ? pwdata[COUNT_BITS-1:0] : base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else begin
         base_ff <= base_in;
      end
   end

   assign prdata         = hit ? DATA_BITS'(base_ff) : '0;
   assign pready         = 1'b1;
   assign new_index_base = base_ff;
   assign base_written   = write_en;

endmodule

// ----- rtl/core/pcp_checker.sv -----
// Port-level assertions for the polygon plane clip stage, bound to the top level.
module pcp_checker
   import pcp_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 req_command,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_kind,
   input logic [FRAC_BITS-1:0] rsp_fraction,
   input logic                 rsp_last
);

   // A waiting result stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before it was taken");

   // No new request is taken while a result is still offered.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a result is pending");

   // A prime request produces no result.
   a_prime_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == CMD_PRIME) |=> !rsp_valid)
      else $error("prime request produced a result");

   // A kept vertex is always the final result of its request.
   a_kept_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_KEPT) |-> rsp_last && (rsp_fraction == '0))
      else $error("kept vertex not marked last or has a fraction");

   // The crossing fraction never exceeds one.
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_NEW) |-> rsp_fraction <= FRAC_ONE)
      else $error("crossing fraction above one");

endmodule

bind polygon_plane_clip_stage pcp_checker u_pcp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_command  (req_chan.command),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_kind     (rsp_chan.kind),
   .rsp_fraction (rsp_chan.fraction),
   .rsp_last     (rsp_chan.last)
);

// ----- bench/tb_polygon_plane_clip_stage.sv -----
// Self-checking testbench for the polygon plane clip stage: directed and random requests.
module tb_polygon_plane_clip_stage;
   import pcp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IB            = INDEX_BITS_DEFAULT;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_ITEMS  = 700;
   localparam int MAX_POLY      = 8;

   typedef struct {
      logic                 kind;
      logic signed [IB-1:0] out_index;
      logic signed [IB-1:0] from_index;
      logic signed [IB-1:0] to_index;
      logic [FRAC_BITS-1:0] fraction;
      logic                 last;
   } clip_result_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [ADDR_BITS-1:0] paddr;
   logic [DATA_BITS-1:0] pwdata;
   logic [DATA_BITS-1:0] prdata;
   logic                 pready;

   pcp_req_if #(.INDEX_BITS(IB)) req_chan ();
   pcp_rsp_if #(.INDEX_BITS(IB)) rsp_chan ();

   polygon_plane_clip_stage #(.INDEX_BITS(IB)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Clip state as the block should hold it.
   logic [COUNT_BITS-1:0]       index_base;
   logic [COUNT_BITS-1:0]       new_count;
   logic signed [IB-1:0]        prev_vtx;
   logic signed [DIST_BITS-1:0] prev_dist;

   clip_result_type clip_expect_q[$];
   int              mismatch_count = 0;
   int              items_sent     = 0;
   bit              idle_on        = 1'b1;

   always #6 clock = ~clock;

   // Generous upper bound on the whole run.
   initial begin
      #(20_000_000);
      $display("polygon_plane_clip_stage verification failed");
      $finish;
   end

   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Interpolation factor prev/(prev-cur) in Q1.16, truncated and capped at one.
   function automatic logic [FRAC_BITS-1:0] crossing_frac(longint p, longint c);
      longint num;
      longint den;
      longint q;
      if (p == c) return '0;
      num = (p < 0) ? -p : p;
      den = (p > c) ? p - c : c - p;
      q = (num <<< 16) / den;
      if (q > longint'(FRAC_ONE)) q = longint'(FRAC_ONE);
      return FRAC_BITS'(q);
   endfunction

   // Works out the vertices one request produces and queues them in order.
   function automatic void predict_clip(logic cmd, logic signed [IB-1:0] vtx,
                                        logic signed [DIST_BITS-1:0] vtx_dist);
      clip_result_type res;
      logic            prev_in;
      logic            cur_in;
      prev_in = !prev_dist[DIST_BITS-1];
      cur_in  = !vtx_dist[DIST_BITS-1];
      if (cmd == CMD_PROCESS) begin
         if (prev_in != cur_in) begin
            res.kind       = KIND_NEW;
            res.out_index  = ~IB'(longint'(index_base) + longint'(new_count));
            res.from_index = prev_vtx;
            res.to_index   = vtx;
            res.fraction   = crossing_frac(longint'(prev_dist), longint'(vtx_dist));
            res.last       = !cur_in;
            clip_expect_q.push_back(res);
            new_count = new_count + 1'b1;
         end
         if (cur_in) begin
            res.kind       = KIND_KEPT;
            res.out_index  = vtx;
            res.from_index = '0;
            res.to_index   = '0;
            res.fraction   = '0;
            res.last       = 1'b1;
            clip_expect_q.push_back(res);
         end
      end
      prev_vtx  = vtx;
      prev_dist = vtx_dist;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      mismatch_count++;
      if (mismatch_count <= 30)
         $display("[%0t] MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
   endtask

   task automatic check_result();
      clip_result_type want;
      if (clip_expect_q.size() == 0) begin
         report_mismatch("result with nothing expected, out_index",
                         longint'(rsp_chan.out_index), 0);
         return;
      end
      want = clip_expect_q.pop_front();
      if (rsp_chan.kind !== want.kind)
         report_mismatch("kind", rsp_chan.kind, want.kind);
      if (rsp_chan.out_index !== want.out_index)
         report_mismatch("out_index", longint'(rsp_chan.out_index), longint'(want.out_index));
      if (rsp_chan.from_index !== want.from_index)
         report_mismatch("from_index", longint'(rsp_chan.from_index),
                         longint'(want.from_index));
      if (rsp_chan.to_index !== want.to_index)
         report_mismatch("to_index", longint'(rsp_chan.to_index), longint'(want.to_index));
      if (rsp_chan.fraction !== want.fraction)
         report_mismatch("fraction", rsp_chan.fraction, want.fraction);
      if (rsp_chan.last !== want.last)
         report_mismatch("last", rsp_chan.last, want.last);
   endtask

   // Both handshakes are sampled at the edge, before any driven update lands.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) check_result();
         if (req_chan.valid && req_chan.ready)
            predict_clip(req_chan.command, req_chan.vertex_index, req_chan.distance);
      end
   end

   // Result side back-pressure: random stalls, or always ready when idling is off.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!idle_on) begin
            rsp_chan.ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // Sends one request. Valid stays high into the next request unless a gap is taken.
   task automatic send_request(logic cmd, logic signed [IB-1:0] vtx,
                               logic signed [DIST_BITS-1:0] vtx_dist);
      int gap;
      gap = idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.command      <= cmd;
      req_chan.vertex_index <= vtx;
      req_chan.distance     <= vtx_dist;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   // Stops sending and waits until every expected vertex has come out.
   task automatic wait_all_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      wait (clip_expect_q.size() == 0);
      @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(int reg_index, logic [DATA_BITS-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_BITS'(4 * reg_index);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (reg_index == REG_NEW_INDEX_BASE) begin
         index_base = value[COUNT_BITS-1:0];
         new_count  = '0;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check(int reg_index);
      logic [DATA_BITS-1:0] data;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_BITS'(4 * reg_index);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      data = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (data !== DATA_BITS'(index_base))
         report_mismatch("new_index_base readback", data, index_base);
   endtask

   // Writes the base (random upper bits are ignored by the block) and reads it back.
   task automatic set_index_base(logic [COUNT_BITS-1:0] base);
      wait_all_results();
      csr_write(REG_NEW_INDEX_BASE, {COUNT_BITS'($urandom), base});
      csr_check(REG_NEW_INDEX_BASE);
   endtask

   function automatic logic signed [DIST_BITS-1:0] pick_distance();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 40) return DIST_BITS'(int'($urandom_range(0, 2000)) - 1000);
      if (r < 48) return 32'sh7FFF_FFFF;
      if (r < 56) return 32'sh8000_0000;
      if (r < 60) return -32'sd1;
      if (r < 80) return DIST_BITS'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
      return DIST_BITS'($urandom);
   endfunction

   // Processing before any prime uses the cleared previous vertex.
   task automatic test_unprimed_start();
      send_request(CMD_PROCESS, 3, -32'sd1);
      send_request(CMD_PROCESS, 4, 32'sd0);
      wait_all_results();
   endtask

   // Extremes of index and distance, each side combination, exact fractions.
   task automatic test_directed_edges();
      send_request(CMD_PRIME,   65535,  32'sh7FFF_FFFF);
      send_request(CMD_PROCESS, -65536, 32'sh8000_0000);
      send_request(CMD_PROCESS, 0,      32'sd0);
      send_request(CMD_PROCESS, -1,     32'sd1);
      send_request(CMD_PROCESS, 7,      -32'sd1);
      // Both sides dropped: nothing comes out, yet the state moves on.
      send_request(CMD_PROCESS, 8,      -32'sd300);
      send_request(CMD_PRIME,   -2,     -32'sd5);
      send_request(CMD_PROCESS, 9,      -32'sd7);
      send_request(CMD_PRIME,   10,     32'sh0001_0000);
      send_request(CMD_PROCESS, 11,     -32'sh0003_0000);
      send_request(CMD_PROCESS, 12,     32'sh7FFF_FFFF);
      send_request(CMD_PRIME,   13,     32'sd0);
      send_request(CMD_PROCESS, 14,     32'sh8000_0000);
      wait_all_results();
   endtask

   // Highest base so that the new index runs past the count width, then back to zero.
   task automatic test_index_base();
      set_index_base(16'hFFFF);
      send_request(CMD_PRIME,   1, 32'sd100);
      send_request(CMD_PROCESS, 2, -32'sd100);
      send_request(CMD_PROCESS, 3, 32'sd100);
      send_request(CMD_PROCESS, 4, -32'sd100);
      set_index_base(16'h0000);
      send_request(CMD_PROCESS, 5, 32'sd40);
      set_index_base(COUNT_BITS'($urandom));
   endtask

   // Mostly whole polygons (prime with the final vertex, then every vertex),
   // mixed with stray requests, base changes and stretches without idling.
   task automatic test_random_polygons();
      logic signed [IB-1:0]        poly_vtx[MAX_POLY];
      logic signed [DIST_BITS-1:0] poly_dist[MAX_POLY];
      int                          nverts;
      int                          stop_at;
      int                          next_phase;
      int unsigned                 r;
      stop_at    = items_sent + RANDOM_ITEMS;
      next_phase = items_sent + 120;
      while (items_sent < stop_at) begin
         idle_on = ($urandom_range(0, 4) != 0);
         r = $urandom_range(0, 99);
         if (r < 10) begin
            send_request(logic'($urandom_range(0, 1)), IB'($urandom), DIST_BITS'($urandom));
         end else begin
            nverts = ($urandom_range(0, 9) == 0) ? MAX_POLY : $urandom_range(2, 5);
            for (int i = 0; i < nverts; i++) begin
               poly_vtx[i]  = IB'($urandom);
               poly_dist[i] = pick_distance();
            end
            send_request(CMD_PRIME, poly_vtx[nverts-1], poly_dist[nverts-1]);
            for (int i = 0; i < nverts; i++)
               send_request(CMD_PROCESS, poly_vtx[i], poly_dist[i]);
         end
         // Now and then the sender holds off until the block has emptied.
         if ($urandom_range(0, 19) == 0) wait_all_results();
         if (items_sent >= next_phase) begin
            idle_on = 1'b1;
            case ($urandom_range(0, 2))
               0:       set_index_base(16'h0000);
               1:       set_index_base(16'hFFFF);
               default: set_index_base(COUNT_BITS'($urandom));
            endcase
            next_phase = items_sent + 120;
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      index_base = '0;
      new_count  = '0;
      prev_vtx   = '0;
      prev_dist  = '0;
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.command      <= CMD_PRIME;
      req_chan.vertex_index <= '0;
      req_chan.distance     <= '0;
      psel                  <= 1'b0;
      penable               <= 1'b0;
      pwrite                <= 1'b0;
      paddr                 <= '0;
      pwdata                <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_unprimed_start();
      test_directed_edges();
      test_index_base();
      test_random_polygons();

      wait_all_results();
      if (clip_expect_q.size() != 0)
         report_mismatch("vertices still expected", clip_expect_q.size(), 0);
      if (mismatch_count == 0) begin
         $display("polygon_plane_clip_stage verification clean");
      end else begin
         $display("polygon_plane_clip_stage verification failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/pcp_pkg.sv
rtl/core/pcp_if.sv
rtl/core/pcp_divider.sv
rtl/core/pcp_csr.sv
rtl/core/polygon_plane_clip_stage.sv
rtl/core/pcp_checker.sv
bench/tb_polygon_plane_clip_stage.sv
